@@ rtl/core/point_to_equirect_pixel_assert.svh @@
// Assertion macros shared by the panorama pixel mapper.
`ifndef POINT_TO_EQUIRECT_PIXEL_ASSERT_SVH
`define POINT_TO_EQUIRECT_PIXEL_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define PTE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define PTE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PTE_ASSERT_IMP(lbl, ante, cons)
`define PTE_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ rtl/core/pte_pkg.sv @@
// Types, constants and tables for the panorama pixel mapper.
`timescale 1ns / 1ps
`default_nettype none
package pte_pkg;

  localparam int unsigned COORD_BITS        = 20;
  localparam int unsigned CORDIC_STAGES_DEF = 16;
  localparam int unsigned GUARD_BITS        = 8;
  // datapath width: coordinate, guard bits, CORDIC growth and sign
  localparam int unsigned XW    = COORD_BITS + GUARD_BITS + 4;
  localparam int unsigned AW    = 35;
  localparam int unsigned QBITS = 18;
  localparam int unsigned DW    = XW + 17;
  localparam int unsigned THR_W = 38;

  localparam logic signed [17:0] GAIN_Q16  = 18'sd107922;
  localparam logic        [17:0] GAIN2_Q16 = 18'd177722;
  localparam logic [QBITS-1:0]   COS_ONE   = 18'd65536;
  localparam logic [14:0]        COL_CAP   = 15'd8192;
  localparam logic [13:0]        ROW_CAP   = 14'd4096;

  localparam logic [13:0] WIDTH_RST  = 14'd6720;
  localparam logic [12:0] HEIGHT_RST = 13'd3360;
  localparam logic [19:0] MINR_RST   = 20'd307;

  // arctan(2^-i), a full turn being 2^32
  localparam logic [29:0] ATAN_TAB [24] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
    30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
    30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
    30'd166886,    30'd83443,     30'd41722,     30'd20861,
    30'd10430,     30'd5215,      30'd2608,      30'd1304,
    30'd652,       30'd326,       30'd163,       30'd81
  };

  typedef enum logic [1:0] {
    CFG_WIDTH     = 2'd0,
    CFG_HEIGHT    = 2'd1,
    CFG_MIN_RANGE = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] pos_z;
  } in_t;

  typedef struct packed {
    logic [12:0] pix_col;
    logic [11:0] pix_row;
    logic        hit;
  } out_t;

  // one CORDIC vector with its accumulated angle
  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [AW-1:0] a;
  } vec_t;

endpackage
`default_nettype wire

@@ rtl/core/pte_cordic_stage.sv @@
// One registered vectoring-mode CORDIC iteration.
`timescale 1ns / 1ps
`default_nettype none
module pte_cordic_stage #(
  parameter int unsigned SHIFT = 0
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  pte_pkg::vec_t vec_i,
  output pte_pkg::vec_t vec_o
);
  import pte_pkg::*;

  vec_t                 vec_d, vec_q;
  logic signed [XW-1:0] dx, dy;
  logic signed [AW-1:0] da;

  // rotate toward the x axis by the stage angle
  always_comb begin
    dx = vec_i.y >>> SHIFT;
    dy = vec_i.x >>> SHIFT;
    da = {{(AW-30){1'b0}}, ATAN_TAB[SHIFT]};
    if (!vec_i.y[XW-1]) begin
      vec_d.x = vec_i.x + dx;
      vec_d.y = vec_i.y - dy;
      vec_d.a = vec_i.a + da;
    end else begin
      vec_d.x = vec_i.x - dx;
      vec_d.y = vec_i.y + dy;
      vec_d.a = vec_i.a - da;
    end
  end

  // hold while the next stage is stalled
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vec_q <= vec_d;
    end
  end

  assign vec_o = vec_q;

endmodule
`default_nettype wire

@@ rtl/core/point_to_equirect_pixel.sv @@
// Throughput: one point per cycle; each stage stalls only when full and blocked.
// Depth is set by two CORDIC chains in series and an 18-stage restoring divider.
// Reset clears all stage valid bits and loads the default panorama registers.
// The output register lets a new word enter while a finished word waits.
`timescale 1ns / 1ps
`default_nettype none
`include "point_to_equirect_pixel_assert.svh"
module point_to_equirect_pixel #(
  parameter int unsigned CORDIC_STAGES = pte_pkg::CORDIC_STAGES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  pte_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output pte_pkg::out_t out_data_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [1:0]    cfg_index_i,
  input  logic [19:0]   cfg_data_i
);
  import pte_pkg::*;

  localparam int unsigned N  = CORDIC_STAGES;
  localparam int unsigned HI = 1 + 2 * N;
  localparam int unsigned DI = HI + 1;
  localparam int unsigned M1 = DI + QBITS;
  localparam int unsigned M2 = M1 + 1;
  localparam int unsigned OI = M2 + 1;
  localparam int unsigned L  = OI + 1;

  // configuration
  logic [13:0]      width_q;
  logic [12:0]      height_q;
  logic [19:0]      minr_q;
  logic [THR_W-1:0] thr_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      minr_q   <= MINR_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_WIDTH:     width_q  <= cfg_data_i[13:0];
        CFG_HEIGHT:    height_q <= cfg_data_i[12:0];
        CFG_MIN_RANGE: minr_q   <= cfg_data_i;
        default:       ;
      endcase
    end
  end

  // range threshold, scaled by the squared CORDIC gain
  always_ff @(posedge clk_i) begin
    thr_q <= THR_W'(minr_q) * THR_W'(GAIN2_Q16);
  end

  // stage valid bits and stall chain
  logic [L-1:0] v_q, v_d;
  logic [L:0]   en;

  always_comb begin
    en[L] = out_ready_i;
    for (int k = L - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
    for (int k = 0; k < L; k++) begin
      if (en[k]) begin
        v_d[k] = (k == 0) ? in_valid_i : v_q[(k == 0) ? 0 : k - 1];
      end else begin
        v_d[k] = v_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[L-1];

  // stage 0: scale, negate z, apply gain to z, fold the left half plane
  logic signed [XW-1:0]    xs, ys, zs, zn;
  logic signed [XW+17:0]   zprod;
  vec_t                    s0_d, s0_q;
  logic signed [XW-1:0]    s0_zk_q;
  localparam logic signed [AW-1:0] HALF_TURN = {{(AW-32){1'b0}}, 32'h8000_0000};

  always_comb begin
    xs = {{(XW-COORD_BITS-GUARD_BITS){in_data_i.pos_x[COORD_BITS-1]}},
          in_data_i.pos_x, {GUARD_BITS{1'b0}}};
    ys = {{(XW-COORD_BITS-GUARD_BITS){in_data_i.pos_y[COORD_BITS-1]}},
          in_data_i.pos_y, {GUARD_BITS{1'b0}}};
    zs = {{(XW-COORD_BITS-GUARD_BITS){in_data_i.pos_z[COORD_BITS-1]}},
          in_data_i.pos_z, {GUARD_BITS{1'b0}}};
    zn    = -zs;
    zprod = zn * GAIN_Q16;
    if (xs[XW-1]) begin
      s0_d.a = ys[XW-1] ? -HALF_TURN : HALF_TURN;
      s0_d.x = -xs;
      s0_d.y = -ys;
    end else begin
      s0_d.a = '0;
      s0_d.x = xs;
      s0_d.y = ys;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s0_q    <= s0_d;
      s0_zk_q <= zprod[XW+15:16];
    end
  end

  // azimuth CORDIC on (x, y), z rides along
  vec_t                 c1_in [N];
  vec_t                 c1_out [N];
  logic signed [XW-1:0] c1_zk_q [N];

  for (genvar k = 0; k < N; k++) begin : g_c1
    if (k == 0) begin : g_first
      assign c1_in[k] = s0_q;
      always_ff @(posedge clk_i) begin
        if (en[1+k]) begin
          c1_zk_q[k] <= s0_zk_q;
        end
      end
    end else begin : g_rest
      assign c1_in[k] = c1_out[k-1];
      always_ff @(posedge clk_i) begin
        if (en[1+k]) begin
          c1_zk_q[k] <= c1_zk_q[k-1];
        end
      end
    end
    pte_cordic_stage #(.SHIFT(k)) u_stage (
      .clk_i (clk_i),
      .en_i  (en[1+k]),
      .vec_i (c1_in[k]),
      .vec_o (c1_out[k])
    );
  end

  // elevation CORDIC on (rho, -z), rho and azimuth ride along
  vec_t                 c2_in [N];
  vec_t                 c2_out [N];
  logic signed [XW-1:0] c2_rho_q [N];
  logic signed [AW-1:0] c2_a1_q [N];

  for (genvar k = 0; k < N; k++) begin : g_c2
    if (k == 0) begin : g_first
      assign c2_in[k].x = c1_out[N-1].x;
      assign c2_in[k].y = c1_zk_q[N-1];
      assign c2_in[k].a = '0;
      always_ff @(posedge clk_i) begin
        if (en[1+N+k]) begin
          c2_rho_q[k] <= c1_out[N-1].x;
          c2_a1_q[k]  <= c1_out[N-1].a;
        end
      end
    end else begin : g_rest
      assign c2_in[k] = c2_out[k-1];
      always_ff @(posedge clk_i) begin
        if (en[1+N+k]) begin
          c2_rho_q[k] <= c2_rho_q[k-1];
          c2_a1_q[k]  <= c2_a1_q[k-1];
        end
      end
    end
    pte_cordic_stage #(.SHIFT(k)) u_stage (
      .clk_i (clk_i),
      .en_i  (en[1+N+k]),
      .vec_i (c2_in[k]),
      .vec_o (c2_out[k])
    );
  end

  // range test and divider setup
  logic [XW-2:0]        r2;
  logic                 hit_d, zero_d;
  logic [DW-1:0]        num_d;
  logic                 h_hit_q, h_zero_q;
  logic [DW-1:0]        h_num_q;
  logic [XW-2:0]        h_den_q;
  logic signed [AW-1:0] h_a1_q, h_a2_q;

  always_comb begin
    r2     = c2_out[N-1].x[XW-1] ? '0 : c2_out[N-1].x[XW-2:0];
    hit_d  = {r2, {GUARD_BITS{1'b0}}} >= (XW - 1 + GUARD_BITS)'(thr_q);
    num_d  = DW'(c2_rho_q[N-1][XW-2:0]) * DW'(GAIN_Q16[16:0]);
    zero_d = (r2 == '0) || c2_rho_q[N-1][XW-1] || (c2_rho_q[N-1] == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en[HI]) begin
      h_hit_q  <= hit_d;
      h_zero_q <= zero_d;
      h_num_q  <= num_d;
      h_den_q  <= r2;
      h_a1_q   <= c2_a1_q[N-1];
      h_a2_q   <= c2_out[N-1].a;
    end
  end

  // restoring divider for cos(phi), one quotient bit per stage
  logic [DW-1:0]        dv_rem_q [QBITS];
  logic [QBITS-1:0]     dv_quo_q [QBITS];
  logic [XW-2:0]        dv_den_q [QBITS];
  logic                 dv_hit_q [QBITS];
  logic                 dv_zero_q [QBITS];
  logic signed [AW-1:0] dv_a1_q [QBITS];
  logic signed [AW-1:0] dv_a2_q [QBITS];

  for (genvar d = 0; d < QBITS; d++) begin : g_div
    localparam int unsigned J = QBITS - 1 - d;
    logic [DW-1:0]        rem_i, sub;
    logic [QBITS-1:0]     quo_i;
    logic [XW-2:0]        den_i;
    logic                 hit_i, zero_i, take;
    logic signed [AW-1:0] a1_i, a2_i;

    if (d == 0) begin : g_first
      assign rem_i  = h_num_q;
      assign quo_i  = '0;
      assign den_i  = h_den_q;
      assign hit_i  = h_hit_q;
      assign zero_i = h_zero_q;
      assign a1_i   = h_a1_q;
      assign a2_i   = h_a2_q;
    end else begin : g_rest
      assign rem_i  = dv_rem_q[d-1];
      assign quo_i  = dv_quo_q[d-1];
      assign den_i  = dv_den_q[d-1];
      assign hit_i  = dv_hit_q[d-1];
      assign zero_i = dv_zero_q[d-1];
      assign a1_i   = dv_a1_q[d-1];
      assign a2_i   = dv_a2_q[d-1];
    end

    assign sub  = DW'(den_i) << J;
    assign take = rem_i >= sub;

    always_ff @(posedge clk_i) begin
      if (en[DI+d]) begin
        dv_rem_q[d]  <= take ? rem_i - sub : rem_i;
        dv_quo_q[d]  <= quo_i | (QBITS'(take) << J);
        dv_den_q[d]  <= den_i;
        dv_hit_q[d]  <= hit_i;
        dv_zero_q[d] <= zero_i;
        dv_a1_q[d]   <= a1_i;
        dv_a2_q[d]   <= a2_i;
      end
    end
  end

  // clamp cos, scale both angles by the width
  logic [16:0]              cos_d;
  logic signed [AW+14:0]    p1_d, prow_d;
  logic signed [AW+14:0]    m1_p1_q, m1_prow_q;
  logic [16:0]              m1_cos_q;
  logic                     m1_hit_q;

  always_comb begin
    if (dv_zero_q[QBITS-1]) begin
      cos_d = '0;
    end else if (dv_quo_q[QBITS-1] > COS_ONE) begin
      cos_d = COS_ONE[16:0];
    end else begin
      cos_d = dv_quo_q[QBITS-1][16:0];
    end
    p1_d   = $signed({1'b0, width_q}) * (-dv_a1_q[QBITS-1]);
    prow_d = $signed({1'b0, width_q}) * dv_a2_q[QBITS-1];
  end

  always_ff @(posedge clk_i) begin
    if (en[M1]) begin
      m1_p1_q   <= p1_d;
      m1_prow_q <= prow_d;
      m1_cos_q  <= cos_d;
      m1_hit_q  <= dv_hit_q[QBITS-1];
    end
  end

  // apply cos(phi) to the column term
  logic signed [AW+32:0] p2_d;
  logic signed [AW+32:0] m2_p2_q;
  logic signed [AW+14:0] m2_prow_q;
  logic                  m2_hit_q;

  assign p2_d = m1_p1_q * $signed({1'b0, m1_cos_q});

  always_ff @(posedge clk_i) begin
    if (en[M2]) begin
      m2_p2_q   <= p2_d;
      m2_prow_q <= m1_prow_q;
      m2_hit_q  <= m1_hit_q;
    end
  end

  // offset to the image center and clamp to the edges
  logic signed [20:0] col;
  logic signed [18:0] row;
  logic [14:0]        col_lim;
  logic [13:0]        row_lim;
  out_t               out_d, out_q;

  always_comb begin
    col     = 21'($signed(m2_p2_q[AW+32:48])) + $signed({8'b0, width_q[13:1]});
    row     = 19'($signed(m2_prow_q[AW+14:32])) + $signed({7'b0, height_q[12:1]});
    col_lim = ({1'b0, width_q} > COL_CAP) ? COL_CAP : {1'b0, width_q};
    row_lim = ({1'b0, height_q} > ROW_CAP) ? ROW_CAP : {1'b0, height_q};
    out_d   = '0;
    if (m2_hit_q) begin
      out_d.hit = 1'b1;
      if (col_lim == '0 || col[20]) begin
        out_d.pix_col = '0;
      end else if (col[19:0] > 20'(col_lim - 15'd1)) begin
        out_d.pix_col = 13'(col_lim - 15'd1);
      end else begin
        out_d.pix_col = col[12:0];
      end
      if (row_lim == '0 || row[18]) begin
        out_d.pix_row = '0;
      end else if (row[17:0] > 18'(row_lim - 14'd1)) begin
        out_d.pix_row = 12'(row_lim - 14'd1);
      end else begin
        out_d.pix_row = row[11:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[OI]) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

  // checks
  `PTE_ASSERT_NXT(a_enter, (in_valid_i && in_ready_o), v_q[0])
  `PTE_ASSERT_IMP(a_miss_zero, (out_valid_o && !out_data_o.hit),
                  (out_data_o.pix_col == '0 && out_data_o.pix_row == '0))
  `PTE_ASSERT_IMP(a_col_in, (out_valid_o && out_data_o.hit && width_q != '0),
                  ({1'b0, out_data_o.pix_col} < width_q))
  `PTE_ASSERT_IMP(a_cos_max, v_q[M1], (m1_cos_q <= COS_ONE[16:0]))

endmodule
`default_nettype wire
